// ===== rtl/core/spch_pkg.sv =====
// Package for the split path CRC hash block.
// Holds the CRC constants, the case fold and the byte-wise CRC update.
// No dependencies.
package spch_pkg;

  localparam int unsigned HalfW = 32;
  localparam int unsigned HashW = 2 * HalfW;

  localparam logic [7:0]       SlashChar = 8'h2F;
  localparam logic [7:0]       UpperA    = 8'h41;
  localparam logic [7:0]       UpperZ    = 8'h5A;
  localparam logic [7:0]       CaseBit   = 8'h20;
  localparam logic [HalfW-1:0] CrcPoly   = 32'hEDB88320;
  localparam logic [HalfW-1:0] CrcInit   = 32'hFFFFFFFF;

  // ASCII upper case to lower case; every other byte passes unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UpperA && b <= UpperZ) begin
      r = b | CaseBit;
    end
    return r;
  endfunction

  // Reflected CRC-32 update by one byte, one bit per step.
  function automatic logic [HalfW-1:0] crc_byte(input logic [HalfW-1:0] crc,
                                                input logic [7:0] b);
    logic [HalfW-1:0] c;
    c = crc ^ {{(HalfW-8){1'b0}}, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/split_path_crc_hash.sv =====
// Top level of the split path CRC hash block: input register, CRC state, result register.
// Depends on spch_pkg for constants and the CRC update function.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------
//   input    | in_valid_i / in_ready_o | path_byte_i[7:0], last_byte_i
//   output   | out_valid_o/out_ready_i | path_hash_o[63:0]
//
// One word is taken per clock unless an output stall holds a word that ends a path.
// A word is held in the input register and its CRC update runs between that register
// and the CRC state; a hash is written to the result register as its last word moves on.
// Reset clears the valid flags and returns the CRC state to all ones.
// A stall on the output holds only a word that ends a path; other words keep
// flowing into the CRC state while a finished hash waits to be taken.
module split_path_crc_hash import spch_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       path_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HashW-1:0] path_hash_o
);

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Path state.
  logic [HalfW-1:0] whole_crc_q, whole_crc_d;
  logic [HalfW-1:0] name_crc_q, name_crc_d;
  logic [HalfW-1:0] dir_snap_q, dir_snap_d;
  logic             slash_seen_q, slash_seen_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [HashW-1:0] hash_q;

  logic             advance;
  logic             in_fire;
  logic [7:0]       folded;
  logic             is_slash;
  logic [HalfW-1:0] whole_next;
  logic [HalfW-1:0] name_next;
  logic [HalfW-1:0] snap_next;
  logic             seen_next;
  logic [HashW-1:0] hash_next;

  // The held word moves on unless it ends a path and the result register is
  // still occupied by a hash that has not been taken.
  assign advance    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    folded     = fold_case(s1_byte_q);
    is_slash   = (folded == SlashChar);
    whole_next = crc_byte(whole_crc_q, folded);
    if (is_slash) begin
      snap_next = whole_crc_q;
      name_next = CrcInit;
      seen_next = 1'b1;
    end else begin
      snap_next = dir_snap_q;
      name_next = crc_byte(name_crc_q, folded);
      seen_next = slash_seen_q;
    end
    // Without a slash both halves carry the CRC of the whole path.
    if (seen_next) begin
      hash_next = {snap_next, name_next};
    end else begin
      hash_next = {whole_next, whole_next};
    end
  end

  always_comb begin
    s1_valid_d   = s1_valid_q;
    whole_crc_d  = whole_crc_q;
    name_crc_d   = name_crc_q;
    dir_snap_d   = dir_snap_q;
    slash_seen_d = slash_seen_q;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      s1_valid_d = 1'b0;
      if (s1_last_q) begin
        // The path is complete: issue the hash and start afresh.
        out_valid_d  = 1'b1;
        whole_crc_d  = CrcInit;
        name_crc_d   = CrcInit;
        dir_snap_d   = CrcInit;
        slash_seen_d = 1'b0;
      end else begin
        whole_crc_d  = whole_next;
        name_crc_d   = name_next;
        dir_snap_d   = snap_next;
        slash_seen_d = seen_next;
      end
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      whole_crc_q  <= CrcInit;
      name_crc_q   <= CrcInit;
      dir_snap_q   <= CrcInit;
      slash_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      whole_crc_q  <= whole_crc_d;
      name_crc_q   <= name_crc_d;
      dir_snap_q   <= dir_snap_d;
      slash_seen_q <= slash_seen_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= path_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (advance && s1_last_q) begin
      hash_q <= hash_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_hash_o = hash_q;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while a finished path was blocked");

  a_path_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=> (whole_crc_q == CrcInit && !slash_seen_q))
    else $error("path state not cleared after the last word");

  a_path_end_issues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=> out_valid_q)
    else $error("hash not issued after the last word");

  a_no_slash_same_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slash_seen_q |-> (name_crc_q == whole_crc_q))
    else $error("name CRC drifted from the whole CRC before any slash");
`endif

endmodule
